// ===== sv/laae_pkg.sv =====
//------------------------------------------------------------------------------
// laae_pkg
// Shared types, constants and the sine table generator of the LED ambient
// effect animator.
//------------------------------------------------------------------------------
`default_nettype none

package laae_pkg;

   localparam int unsigned SINE_TABLE_DEPTH_DEF = 256;
   localparam int unsigned PHASE_BITS_DEF       = 16;

   localparam logic [15:0] Q15_ONE     = 16'd32768;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_AMBIENT_LEVELS   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FLOW_SPEEDS      = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_THERMAL_WINDOW   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_THERMAL_GAIN     = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SMOOTHING_RATE   = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_OSCILLATOR_RATES = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_AMPLITUDES       = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_BREATHING_ENABLE = 4'd7;

   typedef struct packed {
      logic [31:0]        ambient_levels;
      logic [31:0]        flow_speeds;
      logic [31:0]        thermal_window;
      logic signed [15:0] thermal_gain;
      logic [15:0]        smoothing_rate;
      logic [31:0]        oscillator_rates;
      logic [31:0]        amplitudes;
      logic               breathing_enable;
   } cfg_type;

   // Quarter-wave sine entry in Q1.15, odd Taylor series through x^13 in Q30.
   function automatic logic [15:0] sine_entry(input logic [12:0] idx,
                                              input int unsigned depth_log2);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        r;
      logic signed [65:0] sum;
      x    = (HALF_PI_Q30 * 64'(idx)) >> depth_log2;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed({2'b00, x});
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed({2'b00, term});
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed({2'b00, term});
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed({2'b00, term});
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed({2'b00, term});
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed({2'b00, term});
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + $signed({2'b00, term});
      if (sum < 0) begin
         sum = '0;
      end
      r = (sum[63:0] + 64'd16384) >> 15;
      if (r > 64'(Q15_ONE)) begin
         r = 64'(Q15_ONE);
      end
      return r[15:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/laae_ifs.sv =====
//------------------------------------------------------------------------------
// laae channel interfaces
// Valid/ready channels for frame words, result words and register writes.
//------------------------------------------------------------------------------
`default_nettype none

interface laae_req_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] activity_level;
   logic               activity_valid;
   logic signed [15:0] temperature;
   logic               temperature_valid;
   logic signed [16:0] elapsed_time;
   modport source (output valid, activity_level, activity_valid, temperature,
                   temperature_valid, elapsed_time, input ready);
   modport sink   (input valid, activity_level, activity_valid, temperature,
                   temperature_valid, elapsed_time, output ready);
endinterface

interface laae_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] ambient_intensity;
   logic [15:0] warmth_level;
   logic [15:0] flow_angle;
   logic [15:0] pulse_level;
   modport source (output valid, ambient_intensity, warmth_level, flow_angle,
                   pulse_level, input ready);
   modport sink   (input valid, ambient_intensity, warmth_level, flow_angle,
                   pulse_level, output ready);
endinterface

interface laae_csr_if;
   logic                              valid;
   logic                              ready;
   logic [laae_pkg::CSR_INDEX_W-1:0] index;
   logic [laae_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/laae_mul.sv =====
//------------------------------------------------------------------------------
// laae_mul
// Shared 32x32 unsigned multiplier with a registered product.
//------------------------------------------------------------------------------
`default_nettype none

module laae_mul (
   input  wire logic        clock,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic      [63:0] prod_ff
);

   logic [63:0] prod_in;

   assign prod_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ===== sv/laae_core.sv =====
//------------------------------------------------------------------------------
// laae_core
// Sequencer and datapath: restoring divider for the thermal position, then a
// fixed program of multiplies through the shared multiplier.
//------------------------------------------------------------------------------
`default_nettype none

module laae_core #(
   parameter int unsigned SINE_TABLE_DEPTH = laae_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int unsigned PHASE_BITS       = laae_pkg::PHASE_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire laae_pkg::cfg_type cfg,
   laae_req_if.sink               req,
   laae_rsp_if.source             rsp
);

   localparam int unsigned DB = $clog2(SINE_TABLE_DEPTH);
   localparam int unsigned QB = PHASE_BITS - 2;
   localparam int unsigned SH = 28 - PHASE_BITS;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_DIV  = 5'd1;
   localparam logic [4:0] ST_M1   = 5'd2;
   localparam logic [4:0] ST_M2   = 5'd3;
   localparam logic [4:0] ST_M3   = 5'd4;
   localparam logic [4:0] ST_M4   = 5'd5;
   localparam logic [4:0] ST_M5   = 5'd6;
   localparam logic [4:0] ST_M6   = 5'd7;
   localparam logic [4:0] ST_M7   = 5'd8;
   localparam logic [4:0] ST_M8   = 5'd9;
   localparam logic [4:0] ST_M9   = 5'd10;
   localparam logic [4:0] ST_M10  = 5'd11;
   localparam logic [4:0] ST_M11  = 5'd12;
   localparam logic [4:0] ST_M12  = 5'd13;
   localparam logic [4:0] ST_M13  = 5'd14;
   localparam logic [4:0] ST_M14  = 5'd15;
   localparam logic [4:0] ST_M15  = 5'd16;
   localparam logic [4:0] ST_M16  = 5'd17;
   localparam logic [4:0] ST_M17  = 5'd18;
   localparam logic [4:0] ST_M18  = 5'd19;
   localparam logic [4:0] ST_M19  = 5'd20;
   localparam logic [4:0] ST_M20  = 5'd21;
   localparam logic [4:0] ST_M21  = 5'd22;
   localparam logic [4:0] ST_OUT  = 5'd23;

   localparam logic [1:0] T_ZERO = 2'd0;
   localparam logic [1:0] T_FULL = 2'd1;
   localparam logic [1:0] T_QUO  = 2'd2;

   typedef logic [15:0] rom_type [SINE_TABLE_DEPTH];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int i = 0; i < int'(SINE_TABLE_DEPTH); i++) begin
         rom[i] = laae_pkg::sine_entry(13'(i), DB);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   function automatic logic [17:0] rnd15(input logic [33:0] v);
      logic [33:0] s;
      s = v + 34'd16384;
      return s[32:15];
   endfunction

   logic [4:0]  state_ff, state_in;
   logic [3:0]  div_cnt_ff;
   logic [15:0] a_ff, dt_ff, span_ff, rem_ff, t_ff;
   logic [14:0] quo_ff;
   logic [1:0]  t_mode_ff;
   logic        act_ok_ff, warm_en_ff, primed_ff, brn_neg_ff;
   logic [15:0] s_a_ff, warm_t_ff, amb_t_ff, k_ff, pamp_ff;
   logic [15:0] eased_amb_ff, eased_warm_ff;
   logic [16:0] term_ff;
   logic [32:0] acc_ff;
   logic [PHASE_BITS-1:0] flow_ff, breathe_ff, pulse_ff;
   logic [15:0] out_amb_ff, out_warm_ff, out_pulse_ff;
   logic [63:0] prod_ff;
   logic [31:0] op_a, op_b;

   logic signed [15:0] lo, hi;
   logic signed [16:0] span_s, num_s;
   logic [16:0] rem2;
   logic [33:0] lerp_sum;
   logic [17:0] lerp_rnd;
   logic [17:0] prod_rnd;
   logic [46:0] smooth_sum;
   logic [22:0] k_raw;
   logic [15:0] k_sat;
   logic [PHASE_BITS-1:0] step;
   logic [PHASE_BITS-1:0] sin_ph;
   logic [QB+DB-1:0] idx_full;
   logic [DB-1:0]    idx;
   logic [DB-1:0]    idx_mir;
   logic [15:0]      sin_mag;
   logic [15:0]      wave;
   logic signed [17:0] amb_sum;

   laae_mul u_mul (.clock(clock), .op_a(op_a), .op_b(op_b), .prod_ff(prod_ff));

   assign lo       = $signed(cfg.thermal_window[15:0]);
   assign hi       = $signed(cfg.thermal_window[31:16]);
   assign span_s   = 17'(hi) - 17'(lo);
   assign num_s    = 17'(req.temperature) - 17'(lo);
   assign rem2     = {rem_ff, 1'b0};
   assign lerp_sum = 34'(acc_ff) + 34'(prod_ff[32:0]);
   assign lerp_rnd = rnd15(lerp_sum);
   assign prod_rnd = rnd15(prod_ff[33:0]);
   assign smooth_sum = prod_ff[46:0] + 47'(1 << 29);
   assign k_raw    = prod_ff[31:9];
   assign k_sat    = (k_raw > 23'(laae_pkg::Q15_ONE)) ? laae_pkg::Q15_ONE : k_raw[15:0];
   assign step     = prod_ff[SH +: PHASE_BITS];

   // Quarter-wave lookup; the mirrored index equal to the depth reads one.
   assign sin_ph   = (state_ff == ST_M19) ? breathe_ff : pulse_ff;
   assign idx_full = (QB+DB)'({sin_ph[QB-1:0], {DB{1'b0}}} >> QB);
   assign idx      = idx_full[DB-1:0];
   assign idx_mir  = DB'(SINE_TABLE_DEPTH - 32'(idx));
   always_comb begin
      if (!sin_ph[PHASE_BITS-2]) begin
         sin_mag = SINE_ROM[idx];
      end else if (idx == '0) begin
         sin_mag = laae_pkg::Q15_ONE;
      end else begin
         sin_mag = SINE_ROM[idx_mir];
      end
   end

   // Pulse wave is (sin + 1) / 2 on the Q1.15 scale.
   assign wave = sin_ph[PHASE_BITS-1] ? 16'((17'd32768 - 17'(sin_mag)) >> 1)
                                      : 16'((17'd32768 + 17'(sin_mag)) >> 1);

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_M1:  begin op_a = 32'(a_ff); op_b = 32'(a_ff); end
         ST_M2:  begin op_a = prod_ff[31:0]; op_b = 32'(17'd98304 - {a_ff, 1'b0}); end
         ST_M3:  begin op_a = 32'(t_ff); op_b = 32'(t_ff); end
         ST_M4:  begin op_a = prod_ff[31:0]; op_b = 32'(17'd98304 - {t_ff, 1'b0}); end
         ST_M5:  begin
            op_a = 32'(smooth_sum[45:30]);
            op_b = (cfg.thermal_gain > $signed(17'(laae_pkg::Q15_ONE)))
                   ? 32'(laae_pkg::Q15_ONE) : 32'(cfg.thermal_gain[15:0]);
         end
         ST_M6:  begin
            op_a = 32'(cfg.ambient_levels[15:0]);
            op_b = 32'(laae_pkg::Q15_ONE - s_a_ff);
         end
         ST_M7:  begin op_a = 32'(cfg.ambient_levels[31:16]); op_b = 32'(s_a_ff); end
         ST_M8:  begin op_a = 32'(cfg.smoothing_rate); op_b = 32'(dt_ff); end
         ST_M9:  begin op_a = 32'(eased_amb_ff); op_b = 32'(laae_pkg::Q15_ONE - k_sat); end
         ST_M10: begin op_a = 32'(amb_t_ff); op_b = 32'(k_ff); end
         ST_M11: begin op_a = 32'(eased_warm_ff); op_b = 32'(laae_pkg::Q15_ONE - k_ff); end
         ST_M12: begin op_a = 32'(warm_t_ff); op_b = 32'(k_ff); end
         ST_M13: begin
            op_a = 32'(cfg.flow_speeds[15:0]);
            op_b = 32'(laae_pkg::Q15_ONE - a_ff);
         end
         ST_M14: begin op_a = 32'(cfg.flow_speeds[31:16]); op_b = 32'(a_ff); end
         ST_M15: begin op_a = 32'(lerp_rnd[15:0]); op_b = 32'(dt_ff); end
         ST_M16: begin op_a = 32'(cfg.oscillator_rates[15:0]); op_b = 32'(dt_ff); end
         ST_M17: begin op_a = 32'(cfg.oscillator_rates[31:16]); op_b = 32'(dt_ff); end
         ST_M18: begin op_a = 32'(cfg.amplitudes[31:16]); op_b = 32'(a_ff); end
         ST_M19: begin op_a = 32'(sin_mag); op_b = 32'(cfg.amplitudes[15:0]); end
         ST_M20: begin op_a = 32'(pamp_ff); op_b = 32'(wave); end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req.valid) state_in = ST_DIV;
         ST_DIV:  if (div_cnt_ff == 4'd14) state_in = ST_M1;
         ST_M21:  state_in = ST_OUT;
         ST_OUT:  if (rsp.ready) state_in = ST_IDLE;
         default: state_in = state_ff + 5'd1;
      endcase
   end

   assign amb_sum = brn_neg_ff ? (18'(eased_amb_ff) - 18'(term_ff))
                               : (18'(eased_amb_ff) + 18'(term_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         primed_ff     <= 1'b0;
         eased_amb_ff  <= '0;
         eased_warm_ff <= '0;
         flow_ff       <= '0;
         breathe_ff    <= '0;
         pulse_ff      <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_M11: eased_amb_ff <= primed_ff ? lerp_rnd[15:0] : amb_t_ff;
            ST_M13: begin
               eased_warm_ff <= primed_ff ? lerp_rnd[15:0] : warm_t_ff;
               primed_ff     <= 1'b1;
            end
            ST_M16: flow_ff    <= flow_ff + step;
            ST_M17: breathe_ff <= breathe_ff + step;
            ST_M18: pulse_ff   <= pulse_ff + step;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            act_ok_ff <= req.activity_valid;
            if (!req.activity_valid || req.activity_level[16]) begin
               a_ff <= '0;
            end else if (req.activity_level > $signed(17'(laae_pkg::Q15_ONE))) begin
               a_ff <= laae_pkg::Q15_ONE;
            end else begin
               a_ff <= req.activity_level[15:0];
            end
            dt_ff      <= req.elapsed_time[16] ? '0 : req.elapsed_time[15:0];
            warm_en_ff <= req.temperature_valid && (cfg.thermal_gain > 0) && (hi > lo);
            span_ff    <= span_s[15:0];
            rem_ff     <= num_s[15:0];
            quo_ff     <= '0;
            div_cnt_ff <= '0;
            if (num_s <= 0) begin
               t_mode_ff <= T_ZERO;
            end else if (num_s >= span_s) begin
               t_mode_ff <= T_FULL;
            end else begin
               t_mode_ff <= T_QUO;
            end
         end
         ST_DIV: begin
            div_cnt_ff <= div_cnt_ff + 4'd1;
            if (rem2 >= 17'(span_ff)) begin
               rem_ff <= 16'(rem2 - 17'(span_ff));
               quo_ff <= {quo_ff[13:0], 1'b1};
            end else begin
               rem_ff <= rem2[15:0];
               quo_ff <= {quo_ff[13:0], 1'b0};
            end
         end
         ST_M1: begin
            case (t_mode_ff)
               T_ZERO:  t_ff <= '0;
               T_FULL:  t_ff <= laae_pkg::Q15_ONE;
               default: t_ff <= {1'b0, quo_ff};
            endcase
         end
         ST_M3:  s_a_ff <= smooth_sum[45:30];
         ST_M6:  warm_t_ff <= warm_en_ff ? prod_rnd[15:0] : '0;
         ST_M7:  acc_ff <= prod_ff[32:0];
         ST_M8:  amb_t_ff <= act_ok_ff ? lerp_rnd[15:0] : cfg.ambient_levels[15:0];
         ST_M9:  k_ff <= k_sat;
         ST_M10: acc_ff <= prod_ff[32:0];
         ST_M12: acc_ff <= prod_ff[32:0];
         ST_M14: acc_ff <= prod_ff[32:0];
         ST_M19: begin
            pamp_ff    <= prod_rnd[15:0];
            brn_neg_ff <= sin_ph[PHASE_BITS-1];
         end
         ST_M20: begin
            term_ff <= (cfg.breathing_enable && cfg.amplitudes[15:0] != '0)
                       ? prod_rnd[16:0] : '0;
         end
         ST_M21: begin
            out_warm_ff <= eased_warm_ff;
            if (amb_sum < 0) begin
               out_amb_ff <= '0;
            end else if (amb_sum > $signed(18'(laae_pkg::Q15_ONE))) begin
               out_amb_ff <= laae_pkg::Q15_ONE;
            end else begin
               out_amb_ff <= amb_sum[15:0];
            end
            out_pulse_ff <= (prod_rnd > 18'(laae_pkg::Q15_ONE))
                            ? laae_pkg::Q15_ONE : prod_rnd[15:0];
         end
         default: ;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.ambient_intensity = out_amb_ff;
   assign rsp.warmth_level      = out_warm_ff;
   assign rsp.pulse_level       = out_pulse_ff;

   generate
      if (PHASE_BITS >= 16) begin : g_flow_down
         assign rsp.flow_angle = flow_ff[PHASE_BITS-1 -: 16];
      end else begin : g_flow_up
         assign rsp.flow_angle = {flow_ff, {(16-PHASE_BITS){1'b0}}};
      end
   endgenerate

endmodule

`default_nettype wire

// ===== sv/led_ambient_effect_animator_unit.sv =====
//------------------------------------------------------------------------------
// led_ambient_effect_animator_unit
// Frame-rate ambient, warmth, flow and pulse animator for an LED strip.
//
//   channel   dir   handshake      word
//   req_chan  in    valid/ready    activity, temperature, elapsed time
//   rsp_chan  out   valid/ready    ambient, warmth, flow angle, pulse
//   csr_chan  in    valid/ready    register index and write data
//
// After a word is accepted the block runs 15 divider steps for the thermal
// position, then the multiply steps of the one shared multiplier.
// The result waits in its output registers until taken, and the block takes
// no new word meanwhile.
// Reset (synchronous, active high) clears the registers, phases and eased state.
// Register writes are always taken.
//------------------------------------------------------------------------------
`default_nettype none

module led_ambient_effect_animator_unit #(
   parameter int unsigned SINE_TABLE_DEPTH = laae_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int unsigned PHASE_BITS       = laae_pkg::PHASE_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   laae_req_if.sink   req_chan,
   laae_rsp_if.source rsp_chan,
   laae_csr_if.sink   csr_chan
);

   laae_pkg::cfg_type cfg_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            laae_pkg::REG_AMBIENT_LEVELS:   cfg_ff.ambient_levels   <= csr_chan.data;
            laae_pkg::REG_FLOW_SPEEDS:      cfg_ff.flow_speeds      <= csr_chan.data;
            laae_pkg::REG_THERMAL_WINDOW:   cfg_ff.thermal_window   <= csr_chan.data;
            laae_pkg::REG_THERMAL_GAIN:     cfg_ff.thermal_gain     <= csr_chan.data[15:0];
            laae_pkg::REG_SMOOTHING_RATE:   cfg_ff.smoothing_rate   <= csr_chan.data[15:0];
            laae_pkg::REG_OSCILLATOR_RATES: cfg_ff.oscillator_rates <= csr_chan.data;
            laae_pkg::REG_AMPLITUDES:       cfg_ff.amplitudes       <= csr_chan.data;
            laae_pkg::REG_BREATHING_ENABLE: cfg_ff.breathing_enable <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   laae_core #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
      .PHASE_BITS(PHASE_BITS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req(req_chan),
      .rsp(rsp_chan)
   );

endmodule

`default_nettype wire

// ===== sv/laae_checker.sv =====
//------------------------------------------------------------------------------
// laae_checker
// Port-level checks of the animator, attached to the top level by bind.
//------------------------------------------------------------------------------
`default_nettype none

module laae_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_ambient,
   input wire logic [15:0] rsp_warmth,
   input wire logic [15:0] rsp_pulse
);

   // Levels are saturated to one on the Q1.15 scale.
   a_levels_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ambient <= 16'd32768 && rsp_warmth <= 16'd32768 &&
                     rsp_pulse <= 16'd32768))
      else $error("result level above one");

   // A word in progress blocks the input.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while busy");

   // One result per word: a taken result is not shown again next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("result repeated");

   // No result shows up right after an accepted word.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("result too early");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind led_ambient_effect_animator_unit laae_checker u_laae_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_ambient(rsp_chan.ambient_intensity),
   .rsp_warmth(rsp_chan.warmth_level),
   .rsp_pulse(rsp_chan.pulse_level)
);

`default_nettype wire
